>>> design/asc_pkg.sv
// Shared constants and controller/datapath command and status types
// for the array statistics and sort core. No dependencies.
`default_nettype none

package asc_pkg;

    // Default store depth and sample width
    localparam int DEPTH_DEF       = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Width of the position field in a result
    localparam int POS_BITS = 6;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // take the request on the input channel
        logic div_start;  // start the mean division
        logic rd_k;       // read the store at the outer index
        logic rd_a;       // read the store at the inner index
        logic pivot_ld;   // load pivot from read data
        logic cmp;        // compare pivot with read data, swap if smaller
        logic wb_k;       // write pivot back at the outer index
        logic k_clr;
        logic k_inc;
        logic a_clr;
        logic a_inc;
        logic out_ld;     // load the output register
        logic clear_run;  // return run statistics to reset values
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic a_is_k;
        logic a_last;
        logic k_last;
        logic div_done;
        logic out_taken;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> design/asc_req_if.sv
// Input request channel: valid/ready handshake with sample payload.
// Depends on asc_pkg for default widths.
`default_nettype none

interface asc_req_if #(
    parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_item;

    modport source (output valid, output sample, output final_item, input ready);
    modport sink   (input valid, input sample, input final_item, output ready);
endinterface

`default_nettype wire

>>> design/asc_res_if.sv
// Result channel: valid/ready handshake carrying one sorted element
// and the run statistics. Depends on asc_pkg for widths.
`default_nettype none

interface asc_res_if #(
    parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = asc_pkg::SAMPLE_BITS_DEF + 6
);
    logic                             valid;
    logic                             ready;
    logic signed [SAMPLE_BITS-1:0]    sorted_value;
    logic [asc_pkg::POS_BITS-1:0]     position;
    logic signed [SUM_BITS-1:0]       total;
    logic signed [SAMPLE_BITS-1:0]    smallest;
    logic signed [SAMPLE_BITS-1:0]    largest;
    logic signed [SAMPLE_BITS-1:0]    mean;
    logic                             overflowed;
    logic                             last_result;

    modport source (
        output valid, output sorted_value, output position, output total,
        output smallest, output largest, output mean, output overflowed,
        output last_result, input ready
    );
    modport sink (
        input valid, input sorted_value, input position, input total,
        input smallest, input largest, input mean, input overflowed,
        input last_result, output ready
    );
endinterface

`default_nettype wire

>>> design/asc_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Standalone; used by asc_datapath.
`default_nettype none

module asc_div #(
    parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = asc_pkg::SAMPLE_BITS_DEF + 6,
    parameter int CNT_BITS    = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic signed [SUM_BITS-1:0]  i_dividend,
    input  wire logic [CNT_BITS-1:0]         i_divisor,
    output logic                             o_done,
    output logic signed [SAMPLE_BITS-1:0]    o_quotient
);
    localparam int SW = $clog2(SUM_BITS + 1);

    logic                   r_busy;
    logic                   r_done;
    logic                   r_neg;
    logic [SW-1:0]          r_step;
    logic [SUM_BITS-1:0]    r_quo;
    logic [CNT_BITS-1:0]    r_rem;
    logic [SUM_BITS-1:0]    r_result;

    logic [CNT_BITS:0]      w_rem_sh;
    logic                   w_ge;
    logic [CNT_BITS:0]      w_rem_sub;
    logic [SUM_BITS-1:0]    n_quo;
    logic [SUM_BITS-1:0]    w_signed_q;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        w_rem_sh   = {r_rem, r_quo[SUM_BITS-1]};
        w_ge       = (w_rem_sh >= {1'b0, i_divisor});
        w_rem_sub  = w_rem_sh - {1'b0, i_divisor};
        n_quo      = {r_quo[SUM_BITS-2:0], w_ge};
        w_signed_q = r_neg ? (~n_quo + 1'b1) : n_quo;
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= SW'(SUM_BITS);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitude, remainder, quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_BITS-1];
            r_quo <= i_dividend[SUM_BITS-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= w_ge ? w_rem_sub[CNT_BITS-1:0] : w_rem_sh[CNT_BITS-1:0];
            if (r_step == SW'(1)) begin
                r_result <= w_signed_q;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_result[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

>>> design/asc_datapath.sv
// Datapath: element store, run statistics, sort pivot and compare,
// output register. Depends on asc_pkg and asc_div.
`default_nettype none

module asc_datapath #(
    parameter int DEPTH       = asc_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = asc_pkg::SAMPLE_BITS_DEF + 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire asc_pkg::t_dp_cmd              i_cmd,
    output asc_pkg::t_dp_sts                   o_sts,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_sorted_value,
    output logic [asc_pkg::POS_BITS-1:0]       o_position,
    output logic signed [SUM_BITS-1:0]         o_total,
    output logic signed [SAMPLE_BITS-1:0]      o_smallest,
    output logic signed [SAMPLE_BITS-1:0]      o_largest,
    output logic signed [SAMPLE_BITS-1:0]      o_mean,
    output logic                               o_overflowed,
    output logic                               o_last_result
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [SAMPLE_BITS-1:0] r_mem [DEPTH];

    logic [CW-1:0]                 r_count;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic                          r_ovf;
    logic [AW-1:0]                 r_k;
    logic [AW-1:0]                 r_a;
    logic signed [SAMPLE_BITS-1:0] r_pivot;
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_value;
    logic [asc_pkg::POS_BITS-1:0]  r_out_pos;
    logic                          r_out_last;

    logic                          w_room;
    logic [CW-1:0]                 w_last_idx;
    logic                          w_k_last;
    logic                          w_swap;
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic signed [SAMPLE_BITS-1:0] w_wdata;
    logic                          w_div_done;

    assign w_room     = (r_count != CW'(DEPTH));
    assign w_last_idx = r_count - 1'b1;
    assign w_k_last   = (CW'(r_k) == w_last_idx);
    assign w_swap     = (r_pivot < r_rd_data);

    // Select the single store write port: load, swap or pivot write-back
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_k;
        w_wdata = r_pivot;
        priority if (i_cmd.load && w_room) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
            w_wdata = i_sample;
        end else if (i_cmd.cmp && w_swap) begin
            w_we    = 1'b1;
            w_waddr = r_a;
        end else if (i_cmd.wb_k) begin
            w_we    = 1'b1;
        end else begin
            w_we    = 1'b0;
        end
    end

    // Element store with registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_k) begin
            r_rd_data <= r_mem[r_k];
        end else if (i_cmd.rd_a) begin
            r_rd_data <= r_mem[r_a];
        end
    end

    // Run statistics: count, sum, overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_run) begin
            r_count <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_room) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_BITS'(i_sample);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Minimum and maximum, seeded by the first stored element
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            if (r_count == '0 || i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (r_count == '0 || i_sample > r_max) begin
                r_max <= i_sample;
            end
        end
    end

    // Sort indexes and pivot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
            r_a <= '0;
        end else begin
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.a_clr) begin
                r_a <= '0;
            end else if (i_cmd.a_inc) begin
                r_a <= r_a + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pivot_ld || (i_cmd.cmp && w_swap)) begin
            r_pivot <= r_rd_data;
        end
    end

    // Output register: hold until the result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_value <= r_rd_data;
            r_out_pos   <= asc_pkg::POS_BITS'(r_k);
            r_out_last  <= w_k_last;
        end
    end

    // Mean: total divided by element count
    asc_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS),
        .CNT_BITS    (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (o_mean)
    );

    always_comb begin
        o_sts.a_is_k    = (r_a == r_k);
        o_sts.a_last    = (CW'(r_a) == w_last_idx);
        o_sts.k_last    = w_k_last;
        o_sts.div_done  = w_div_done;
        o_sts.out_taken = r_out_valid && i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_position     = r_out_pos;
    assign o_total        = r_sum;
    assign o_smallest     = r_min;
    assign o_largest      = r_max;
    assign o_overflowed   = r_ovf;
    assign o_last_result  = r_out_last;

endmodule

`default_nettype wire

>>> design/asc_ctrl.sv
// Controller: sequences load, mean division, exchange sort and result
// emission. Depends on asc_pkg command and status types.
`default_nettype none

module asc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_final,
    output logic                  o_in_ready,
    output asc_pkg::t_dp_cmd      o_cmd,
    input  wire asc_pkg::t_dp_sts i_sts
);
    typedef enum logic [10:0] {
        S_LOAD     = 11'b000_0000_0001,
        S_DIV_GO   = 11'b000_0000_0010,
        S_DIV_WAIT = 11'b000_0000_0100,
        S_PIV_RD   = 11'b000_0000_1000,
        S_PIV_LD   = 11'b000_0001_0000,
        S_SCAN     = 11'b000_0010_0000,
        S_CMP      = 11'b000_0100_0000,
        S_WBK      = 11'b000_1000_0000,
        S_OUT_RD   = 11'b001_0000_0000,
        S_OUT_LD   = 11'b010_0000_0000,
        S_OUT_WAIT = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_final) begin
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.k_clr     = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_PIV_RD;
                end
            end
            S_PIV_RD: begin
                o_cmd.rd_k  = 1'b1;
                o_cmd.a_clr = 1'b1;
                n_state     = S_PIV_LD;
            end
            S_PIV_LD: begin
                o_cmd.pivot_ld = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                // Skip the pivot's own slot, otherwise fetch the partner
                if (i_sts.a_is_k) begin
                    if (i_sts.a_last) begin
                        n_state = S_WBK;
                    end else begin
                        o_cmd.a_inc = 1'b1;
                    end
                end else begin
                    o_cmd.rd_a = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.a_last) begin
                    n_state = S_WBK;
                end else begin
                    o_cmd.a_inc = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_WBK: begin
                o_cmd.wb_k = 1'b1;
                if (i_sts.k_last) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_OUT_RD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_PIV_RD;
                end
            end
            S_OUT_RD: begin
                o_cmd.rd_k = 1'b1;
                n_state    = S_OUT_LD;
            end
            S_OUT_LD: begin
                o_cmd.out_ld = 1'b1;
                n_state      = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.k_last) begin
                        o_cmd.clear_run = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/array_stats_and_sort_core.sv
// Sequence: samples are loaded; after the final sample the mean divider runs,
// then the exchange sort over the single-port store, then the results are emitted
// one at a time, each held until taken.
// Throughput: one sample per cycle while loading; one run at a time.
// Reset: synchronous, active low; clears count, sum, overflow flag, output valid
// and controller state. The element store is not cleared.
`default_nettype none

module array_stats_and_sort_core #(
    parameter int DEPTH       = asc_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    asc_req_if.sink    i_req,
    asc_res_if.source  o_res
);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(DEPTH + 1);

    asc_pkg::t_dp_cmd w_cmd;
    asc_pkg::t_dp_sts w_sts;
    logic             w_in_ready;

    asc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_final (i_req.final_item),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    asc_datapath #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample       (i_req.sample),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_sorted_value (o_res.sorted_value),
        .o_position     (o_res.position),
        .o_total        (o_res.total),
        .o_smallest     (o_res.smallest),
        .o_largest      (o_res.largest),
        .o_mean         (o_res.mean),
        .o_overflowed   (o_res.overflowed),
        .o_last_result  (o_res.last_result)
    );

    assign i_req.ready = w_in_ready;

endmodule

`default_nettype wire

>>> design/asc_checker.sv
// Port-level checker for array_stats_and_sort_core, attached by bind.
// Depends on asc_pkg for the default sample width.
`default_nettype none

module asc_checker #(
    parameter int SAMPLE_BITS = asc_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_req_final,
    input wire logic                          i_res_valid,
    input wire logic                          i_res_ready,
    input wire logic                          i_res_last,
    input wire logic signed [SAMPLE_BITS-1:0] i_res_smallest,
    input wire logic signed [SAMPLE_BITS-1:0] i_res_largest
);
    // No new request is taken while a result is pending
    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !i_req_ready)
        else $error("request accepted while result pending");

    // Final sample closes the input until the run is emitted
    a_final_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && i_req_final) |=> (!i_req_ready && !i_res_valid))
        else $error("input open or result early after final sample");

    // More results follow a non-last result
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && !i_res_last) |=> !i_req_ready)
        else $error("input reopened before last result");

    // Input reopens right after the last result
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && i_res_last) |=> i_req_ready)
        else $error("input not reopened after last result");

    // Statistics are consistent
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_smallest <= i_res_largest))
        else $error("minimum above maximum");

endmodule

bind array_stats_and_sort_core asc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_asc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_final    (i_req.final_item),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_last     (o_res.last_result),
    .i_res_smallest (o_res.smallest),
    .i_res_largest  (o_res.largest)
);

`default_nettype wire

>>> test/array_stats_and_sort_core_tb.sv
// Self-checking bench for array_stats_and_sort_core: drives sample runs and checks the sorted
// results and run statistics against an in-bench predictor.
// Depends on asc_pkg, asc_req_if, asc_res_if and the core itself.
`timescale 1ns / 1ps

module array_stats_and_sort_core_tb;

    localparam int DEPTH = asc_pkg::DEPTH_DEF;
    localparam int SMP_W = asc_pkg::SAMPLE_BITS_DEF;
    localparam int SUM_W = SMP_W + 6;
    localparam int POS_W = asc_pkg::POS_BITS;

    localparam int ITEM_GOAL   = 420;
    localparam int IDLE_PCT    = 25;
    localparam int CALM_FROM   = 4000;
    localparam int CALM_TO     = 12000;
    localparam int DRAIN_TICKS = 200;

    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};

    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic                    fin;
    } t_sample_req;

    typedef struct {
        logic signed [SMP_W-1:0] sorted_value;
        logic [POS_W-1:0]        position;
        logic signed [SUM_W-1:0] total;
        logic signed [SMP_W-1:0] smallest;
        logic signed [SMP_W-1:0] largest;
        logic signed [SMP_W-1:0] mean;
        logic                    overflowed;
        logic                    last_result;
    } t_sorted_res;

    logic i_clk;
    logic i_rst_n;

    asc_req_if #(.SAMPLE_BITS(SMP_W)) req_if ();
    asc_res_if #(.SAMPLE_BITS(SMP_W), .SUM_BITS(SUM_W)) res_if ();

    array_stats_and_sort_core #(
        .DEPTH      (DEPTH),
        .SAMPLE_BITS(SMP_W)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source)
    );

    // Pending samples, expected sorted results, and bench bookkeeping
    t_sample_req pend_q[$];
    t_sorted_res sorted_expect[$];
    int          total_items;
    int          items_taken = 0;
    int          err_count   = 0;
    int          cyc         = 0;
    logic        req_taken   = 1'b0;

    // Predictor state for the run being collected
    logic signed [SMP_W-1:0] stat_store[DEPTH];
    int                      stat_count = 0;
    logic signed [SUM_W-1:0] stat_sum   = '0;
    logic signed [SMP_W-1:0] stat_min   = '0;
    logic signed [SMP_W-1:0] stat_max   = '0;
    logic                    stat_ovf   = 1'b0;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Drive every input to a known value from time zero
    initial begin
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.sample     = '0;
        req_if.final_item = 1'b0;
        res_if.ready      = 1'b0;
    end

    function automatic logic calm_window();
        return (cyc >= CALM_FROM) && (cyc < CALM_TO);
    endfunction

    function automatic logic take_break();
        return !calm_window() && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_count++;
    endtask

    // Fold one accepted sample into the run; on the final sample sort and queue results
    task automatic absorb_sample(input logic signed [SMP_W-1:0] s, input logic fin);
        t_sorted_res             r;
        logic signed [SMP_W-1:0] t;
        longint                  quot;
        int                      n;
        if (stat_count < DEPTH) begin
            stat_store[stat_count] = s;
            if (stat_count == 0) begin
                stat_min = s;
                stat_max = s;
            end else begin
                if (s < stat_min) stat_min = s;
                if (s > stat_max) stat_max = s;
            end
            stat_sum = stat_sum + s;
            stat_count++;
        end else begin
            stat_ovf = 1'b1;
        end
        if (!fin) return;

        // All-pairs exchange sort, ascending
        n = stat_count;
        for (int k = 0; k < n; k++) begin
            for (int a = 0; a < n; a++) begin
                if (stat_store[k] < stat_store[a]) begin
                    t             = stat_store[k];
                    stat_store[k] = stat_store[a];
                    stat_store[a] = t;
                end
            end
        end

        // Division truncates toward zero
        quot = longint'(stat_sum) / n;
        for (int k = 0; k < n; k++) begin
            r.sorted_value = stat_store[k];
            r.position     = k[POS_W-1:0];
            r.total        = stat_sum;
            r.smallest     = stat_min;
            r.largest      = stat_max;
            r.mean         = quot[SMP_W-1:0];
            r.overflowed   = stat_ovf;
            r.last_result  = (k == n - 1);
            sorted_expect.push_back(r);
        end

        stat_count = 0;
        stat_sum   = '0;
        stat_min   = '0;
        stat_max   = '0;
        stat_ovf   = 1'b0;
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        t_sorted_res e;
        if (sorted_expect.size() == 0) begin
            flag_mismatch($sformatf("unexpected result value=%0d pos=%0d",
                                    res_if.sorted_value, res_if.position));
            return;
        end
        e = sorted_expect.pop_front();
        if (res_if.sorted_value !== e.sorted_value)
            flag_mismatch($sformatf("sorted_value got %0d exp %0d (pos %0d)",
                                    res_if.sorted_value, e.sorted_value, e.position));
        if (res_if.position !== e.position)
            flag_mismatch($sformatf("position got %0d exp %0d", res_if.position, e.position));
        if (res_if.total !== e.total)
            flag_mismatch($sformatf("total got %0d exp %0d", res_if.total, e.total));
        if (res_if.smallest !== e.smallest)
            flag_mismatch($sformatf("smallest got %0d exp %0d", res_if.smallest, e.smallest));
        if (res_if.largest !== e.largest)
            flag_mismatch($sformatf("largest got %0d exp %0d", res_if.largest, e.largest));
        if (res_if.mean !== e.mean)
            flag_mismatch($sformatf("mean got %0d exp %0d", res_if.mean, e.mean));
        if (res_if.overflowed !== e.overflowed)
            flag_mismatch($sformatf("overflowed got %b exp %b",
                                    res_if.overflowed, e.overflowed));
        if (res_if.last_result !== e.last_result)
            flag_mismatch($sformatf("last_result got %b exp %b (pos %0d)",
                                    res_if.last_result, e.last_result, e.position));
    endtask

    // Monitor: sample both channels at the rising edge
    always @(posedge i_clk) begin
        cyc       <= cyc + 1;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready)
            check_result();
        if (i_rst_n && req_if.valid && req_if.ready) begin
            absorb_sample(req_if.sample, req_if.final_item);
            items_taken++;
        end
    end

    // Driver: present the next request at the falling edge, hold it until taken
    always @(negedge i_clk) begin
        t_sample_req item;
        if (!i_rst_n) begin
            req_if.valid = 1'b0;
        end else if (!req_if.valid || req_taken) begin
            if (pend_q.size() > 0 && !take_break()) begin
                item              = pend_q.pop_front();
                req_if.sample     = item.sample;
                req_if.final_item = item.fin;
                req_if.valid      = 1'b1;
            end else begin
                req_if.valid = 1'b0;
            end
        end
    end

    // Result back-pressure
    always @(negedge i_clk) begin
        res_if.ready = i_rst_n && !take_break();
    end

    function automatic logic signed [SMP_W-1:0] draw_sample();
        logic [SMP_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = SMP_MIN;
            1: v = SMP_MAX;
            2, 3: v = SMP_W'($urandom_range(0, 15) - 8);  // narrow range gives duplicates
            default: v = SMP_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic push_req(input logic signed [SMP_W-1:0] s, input logic fin);
        t_sample_req item;
        item.sample = s;
        item.fin    = fin;
        pend_q.push_back(item);
    endtask

    task automatic push_random_run(input int len);
        for (int i = 0; i < len; i++)
            push_req(draw_sample(), i == len - 1);
    endtask

    // Stimulus, reset and end of run
    initial begin
        int len;
        int pick;

        // Single-element runs at both extremes
        push_req(SMP_MIN, 1'b1);
        push_req(SMP_MAX, 1'b1);
        // Both extremes together, reversed order
        push_req(SMP_MAX, 1'b0);
        push_req(SMP_MIN, 1'b1);
        // All equal
        push_req(16'sd0, 1'b0);
        push_req(16'sd0, 1'b0);
        push_req(16'sd0, 1'b1);
        // Negative non-integer mean truncates toward zero
        push_req(-16'sd7, 1'b0);
        push_req(16'sd2, 1'b1);
        // Positive non-integer mean
        push_req(16'sd7, 1'b0);
        push_req(-16'sd2, 1'b1);
        // Descending input
        for (int i = 5; i >= 1; i--)
            push_req(i[SMP_W-1:0], i == 1);
        // Minimum repeated, mean at the floor
        push_req(SMP_MIN, 1'b0);
        push_req(SMP_MIN, 1'b0);
        push_req(SMP_MIN, 1'b1);
        // Mixed signs with duplicates
        push_req(-16'sd1, 1'b0);
        push_req(16'sd1, 1'b0);
        push_req(-16'sd1, 1'b0);
        push_req(16'sd5, 1'b1);

        // Store full: final item dropped, then a run with several dropped samples
        push_random_run(DEPTH + 1);
        push_random_run(DEPTH + 4);
        // Full store of maximum values, largest sum
        for (int i = 0; i < DEPTH; i++)
            push_req(SMP_MAX, i == DEPTH - 1);

        // Random runs, mostly short
        while (pend_q.size() < ITEM_GOAL) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      len = $urandom_range(1, 8);
            else if (pick < 85) len = $urandom_range(9, DEPTH - 1);
            else if (pick < 93) len = DEPTH;
            else                len = $urandom_range(DEPTH + 1, DEPTH + 8);
            push_random_run(len);
        end
        total_items = pend_q.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (items_taken == total_items);
        wait (sorted_expect.size() == 0);
        repeat (DRAIN_TICKS) @(posedge i_clk);

        if (sorted_expect.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    sorted_expect.size()));

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Timeout
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
